[rtl/ubls_pkg.sv]
// ----------------------------------------------------------------------------
// ubls_pkg
// Shared types and constants for the bus LED slave: register indexes, reset
// values, parse phases and the result descriptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ubls_pkg;

   // Register indexes on the csr port
   localparam logic [2:0] CSR_OWN_ADDRESS   = 3'd0;
   localparam logic [2:0] CSR_SYNC_BYTE     = 3'd1;
   localparam logic [2:0] CSR_SYNC_NEEDED   = 3'd2;
   localparam logic [2:0] CSR_READ_CODE     = 3'd3;
   localparam logic [2:0] CSR_WRITE_CODE    = 3'd4;
   localparam logic [2:0] CSR_RELEASE_VALUE = 3'd5;

   // Register reset values
   localparam logic [7:0] RST_OWN_ADDRESS   = 8'h01;
   localparam logic [7:0] RST_SYNC_BYTE     = 8'hFC;
   localparam logic [2:0] RST_SYNC_NEEDED   = 3'd3;
   localparam logic [7:0] RST_READ_CODE     = 8'h80;
   localparam logic [7:0] RST_WRITE_CODE    = 8'h00;
   localparam logic [7:0] RST_RELEASE_VALUE = 8'hFF;

   localparam logic [3:0] RST_LEDS = 4'd3;

   // Report frame: sync x3, two fixed bytes, LED nibble
   localparam logic [7:0] RPT_FIXED0 = 8'd10;
   localparam logic [7:0] RPT_FIXED1 = 8'd12;
   localparam logic [7:0] RDCHK_BYTE = 8'h00;
   localparam logic [2:0] BEAT_FIXED0 = 3'd3;
   localparam logic [2:0] BEAT_FIXED1 = 3'd4;
   localparam logic [2:0] BEAT_LAST   = 3'd5;

   localparam logic [1:0] BTN_REPORT = 2'd3;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_ADDR  = 3'd1,
      PH_CMD   = 3'd2,
      PH_RDCHK = 3'd3,
      PH_WDATA = 3'd4,
      PH_SKIP  = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] own_address;
      logic [7:0] sync_byte;
      logic [2:0] sync_needed;
      logic [7:0] read_code;
      logic [7:0] write_code;
      logic [7:0] release_value;
   } cfg_type;

   // What one input item leaves for the result side
   typedef struct packed {
      logic       report;
      logic [3:0] nibble;
      logic [3:0] leds;
      logic       sel;
   } desc_type;

endpackage

`default_nettype wire

[rtl/ubls_parser.sv]
// ----------------------------------------------------------------------------
// ubls_parser
// Input register plus frame parser and LED/selection state; hands one
// descriptor per item to the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ubls_parser
   import ubls_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic       in_command,
   input  wire logic [7:0] in_rx_byte,
   input  wire logic [1:0] in_button,
   input  wire logic       take,
   output logic            push,
   output desc_type        desc
);

   logic       in_vld_ff, in_vld_in;
   logic       cmd_ff;
   logic [7:0] byte_ff;
   logic [1:0] btn_ff;

   phase_type  phase_ff, phase_in;
   logic [2:0] sync_rem_ff, sync_rem_in, sync_dec;
   logic [1:0] skip_rem_ff, skip_rem_in, skip_dec;
   logic [3:0] leds_ff, leds_in;
   logic       sel_ff, sel_in;
   logic       restart, report;
   logic [3:0] nibble;

   assign push      = in_vld_ff && take;
   assign in_ready  = !in_vld_ff || take;
   assign in_vld_in = (in_valid && in_ready) || (in_vld_ff && !take);

   assign sync_dec = (sync_rem_ff != 3'd0) ? sync_rem_ff - 3'd1 : sync_rem_ff;
   assign skip_dec = (skip_rem_ff != 2'd0) ? skip_rem_ff - 2'd1 : skip_rem_ff;

   always_comb begin
      phase_in    = phase_ff;
      sync_rem_in = sync_rem_ff;
      skip_rem_in = skip_rem_ff;
      leds_in     = leds_ff;
      sel_in      = sel_ff;
      restart     = 1'b0;
      report      = 1'b0;
      nibble      = leds_ff;
      if (!cmd_ff) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (byte_ff == cfg.sync_byte) begin
                  sync_rem_in = sync_dec;
                  if (sync_dec == 3'd0) phase_in = PH_ADDR;
               end
            end
            PH_ADDR: begin
               if (byte_ff == cfg.own_address) begin
                  sel_in   = 1'b1;
                  phase_in = PH_CMD;
               end else begin
                  skip_rem_in = 2'd2;
                  phase_in    = PH_SKIP;
               end
            end
            PH_CMD: begin
               // read wins when both codes are equal
               priority if (byte_ff == cfg.read_code) begin
                  phase_in = PH_RDCHK;
               end else if (byte_ff == cfg.write_code) begin
                  phase_in = PH_WDATA;
               end else begin
                  skip_rem_in = 2'd1;
                  phase_in    = PH_SKIP;
               end
            end
            PH_RDCHK: begin
               report  = (byte_ff == RDCHK_BYTE);
               restart = 1'b1;
            end
            PH_WDATA: begin
               if (byte_ff == cfg.release_value) sel_in = 1'b0;
               else leds_in = byte_ff[3:0];
               restart = 1'b1;
            end
            PH_SKIP: begin
               skip_rem_in = skip_dec;
               if (skip_dec == 2'd0) restart = 1'b1;
            end
            default: begin
               restart = 1'b1;
            end
         endcase
         if (restart) begin
            sync_rem_in = cfg.sync_needed;
            phase_in    = (cfg.sync_needed == 3'd0) ? PH_ADDR : PH_HUNT;
            skip_rem_in = 2'd0;
         end
         nibble = leds_in;
      end else begin
         // button press; report carries LEDs before the toggle
         report = (btn_ff == BTN_REPORT);
         if (!sel_ff) leds_in = leds_ff ^ (4'b0001 << btn_ff);
      end
   end

   assign desc = '{report: report, nibble: nibble, leds: leds_in, sel: sel_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         phase_ff    <= (RST_SYNC_NEEDED == 3'd0) ? PH_ADDR : PH_HUNT;
         sync_rem_ff <= RST_SYNC_NEEDED;
         skip_rem_ff <= 2'd0;
         leds_ff     <= RST_LEDS;
         sel_ff      <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (push) begin
            phase_ff    <= phase_in;
            sync_rem_ff <= sync_rem_in;
            skip_rem_ff <= skip_rem_in;
            leds_ff     <= leds_in;
            sel_ff      <= sel_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         cmd_ff  <= in_command;
         byte_ff <= in_rx_byte;
         btn_ff  <= in_button;
      end
   end

endmodule

`default_nettype wire

[rtl/ubls_emitter.sv]
// ----------------------------------------------------------------------------
// ubls_emitter
// Result register and beat counter: one beat for a plain item, six for a
// report frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ubls_emitter
   import ubls_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] sync_byte,
   input  wire logic       push,
   input  wire desc_type   desc,
   output logic            take,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic            out_tx,
   output logic [7:0]      out_byte,
   output logic            out_last,
   output logic [3:0]      out_leds,
   output logic            out_sel
);

   desc_type   dsc_ff;
   logic       dsc_vld_ff;
   logic [2:0] beat_ff;
   logic [7:0] rpt_byte;

   assign out_last  = !dsc_ff.report || (beat_ff == BEAT_LAST);
   assign take      = !dsc_vld_ff || (out_ready && out_last);
   assign out_valid = dsc_vld_ff;
   assign out_tx    = dsc_ff.report;
   assign out_leds  = dsc_ff.leds;
   assign out_sel   = dsc_ff.sel;

   always_comb begin
      unique case (beat_ff)
         BEAT_FIXED0: rpt_byte = RPT_FIXED0;
         BEAT_FIXED1: rpt_byte = RPT_FIXED1;
         BEAT_LAST:   rpt_byte = {4'd0, dsc_ff.nibble};
         default:     rpt_byte = sync_byte;
      endcase
   end

   assign out_byte = dsc_ff.report ? rpt_byte : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dsc_vld_ff <= 1'b0;
         beat_ff    <= 3'd0;
      end else if (push) begin
         dsc_vld_ff <= 1'b1;
         beat_ff    <= 3'd0;
      end else if (dsc_vld_ff && out_ready) begin
         if (out_last) dsc_vld_ff <= 1'b0;
         else beat_ff <= beat_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) dsc_ff <= desc;
   end

endmodule

`default_nettype wire

[rtl/uart_bus_led_slave.sv]
// ----------------------------------------------------------------------------
// uart_bus_led_slave
// Bus slave node with four LEDs and four buttons, fed as a stream of events.
// ----------------------------------------------------------------------------
// Each req transfer is either a received bus byte (tuser 0) or a button press
// (tuser 1). Bus bytes are parsed into frames: sync bytes (gaps allowed), an
// address, a command and one data byte. An item goes into an input register,
// is parsed from there and moves into a result register when taken; a plain
// item gives one rsp transfer, a report (read command with a zero byte, or
// button 3) gives six: sync x3, 10, 12, LED nibble. A new item can be taken
// every cycle while results flow; the single result register and its beat
// counter hold a report until its last beat is accepted, so a new item waits
// behind it. A req transfer passes through the input register and then the
// result register before its first rsp beat. CSR writes go in at any time
// but are meant for idle periods only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uart_bus_led_slave
   import ubls_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // event input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [7:0] rx_byte, [9:8] button_index, rest 0
   input  wire logic        req_tuser,  // [0] command
   // results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // [7:0] tx_byte, [11:8] led_state,
                                        // [12] is_selected, [13] bus_drive, rest 0
   output logic             rsp_tuser,  // [0] tx_valid
   output logic             rsp_tlast,  // tx_last
   // register writes
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   cfg_type    cfg_ff;
   logic       push, take;
   desc_type   desc;
   logic       tx;
   logic [7:0] tx_byte;
   logic [3:0] leds;
   logic       sel;

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address   <= RST_OWN_ADDRESS;
         cfg_ff.sync_byte     <= RST_SYNC_BYTE;
         cfg_ff.sync_needed   <= RST_SYNC_NEEDED;
         cfg_ff.read_code     <= RST_READ_CODE;
         cfg_ff.write_code    <= RST_WRITE_CODE;
         cfg_ff.release_value <= RST_RELEASE_VALUE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS:   cfg_ff.own_address   <= csr_wdata;
            CSR_SYNC_BYTE:     cfg_ff.sync_byte     <= csr_wdata;
            CSR_SYNC_NEEDED:   cfg_ff.sync_needed   <= csr_wdata[2:0];
            CSR_READ_CODE:     cfg_ff.read_code     <= csr_wdata;
            CSR_WRITE_CODE:    cfg_ff.write_code    <= csr_wdata;
            CSR_RELEASE_VALUE: cfg_ff.release_value <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register + parser; state advances when the emitter takes the item
   ubls_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_command (req_tuser),
      .in_rx_byte (req_tdata[7:0]),
      .in_button  (req_tdata[9:8]),
      .take       (take),
      .push       (push),
      .desc       (desc)
   );

   // result register, walks report beats
   ubls_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .sync_byte (cfg_ff.sync_byte),
      .push      (push),
      .desc      (desc),
      .take      (take),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tx    (tx),
      .out_byte  (tx_byte),
      .out_last  (rsp_tlast),
      .out_leds  (leds),
      .out_sel   (sel)
   );

   // bus_drive follows tx_valid: only report bytes drive the bus
   assign rsp_tuser = tx;
   assign rsp_tdata = {2'b00, tx, sel, leds, tx_byte};

   // non-report results are single transfers
   a_plain_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("plain result not marked last");

   // a report frame keeps going until its last beat
   a_report_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser && !rsp_tlast |=> rsp_tvalid && rsp_tuser)
      else $error("report frame broken before last beat");

   // input only stalls behind a pending result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

endmodule

`default_nettype wire
